@@ sv/icg_pkg.sv @@
// Package with constants, field widths and register indexes for the correspondence gate.
`timescale 1ns / 1ps
`default_nettype none
package icg_pkg;
    localparam int MAX_PIXELS_DEFAULT = 524288;
    localparam int SLOT_SPAN = 524288;
    localparam int IDX_W = 19;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COS_THR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CURV_FLOOR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_LIM = 3'd6;
    localparam logic [63:0] ROW_X_RESET = 64'h4000_0000_0000_0000;
    localparam logic [63:0] ROW_Y_RESET = 64'h0000_4000_0000_0000;
    localparam logic [63:0] ROW_Z_RESET = 64'h0000_0000_4000_0000;
    localparam logic [15:0] COS_THR_RESET = 16'd13107;
    localparam logic [31:0] MAX_DIST_RESET = 32'd10486;
    localparam logic [15:0] CURV_FLOOR_RESET = 16'd1311;
    localparam logic [15:0] RATIO_LIM_RESET = 16'd333;
endpackage
`default_nettype wire

@@ sv/icp_correspondence_gate.sv @@
// Top level of the correspondence gate: four-stage transform and rejection pipeline.
// An accepted input transaction passes through the stage 1, 2 and 3 registers and then the output register.
// Throughput: one pixel per cycle; stages advance together whenever the output register is free.
// Stage 1 multiplies the rotation products, stage 2 sums rows and forms the difference,
// stage 3 squares and forms the dot and curvature products, stage 4 compares and counts.
// Reset (asynchronous, rst_n low) restores the identity transform, default thresholds
// and a zero match count, and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module icp_correspondence_gate
    import icg_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // frame_start
    input  wire logic                 s_tuser,
    // ref_index[19:0], cur_index[39:20], ref_point[87:40], ref_normal[135:88],
    // cur_point[183:136], cur_normal[231:184], ref_curvature[247:232],
    // cur_curvature[263:248]
    input  wire logic [263:0]         s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // match_ref_index[18:0], match_cur_index[37:19], match_slot[56:38], zero fill
    output logic [63:0]               m_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data
);
    localparam int LIST_CAP = (MAX_PIXELS < SLOT_SPAN) ? MAX_PIXELS : SLOT_SPAN;
    localparam int CNT_W = $clog2(LIST_CAP + 1);

    logic [63:0] row_reg [3];
    logic signed [15:0] cos_thr_reg;
    logic [31:0] max_dist_reg;
    logic [15:0] curv_floor_reg;
    logic [15:0] ratio_lim_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_X_RESET;
            row_reg[1] <= ROW_Y_RESET;
            row_reg[2] <= ROW_Z_RESET;
            cos_thr_reg <= COS_THR_RESET;
            max_dist_reg <= MAX_DIST_RESET;
            curv_floor_reg <= CURV_FLOOR_RESET;
            ratio_lim_reg <= RATIO_LIM_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROW_X: row_reg[0] <= cfg_data;
                REG_ROW_Y: row_reg[1] <= cfg_data;
                REG_ROW_Z: row_reg[2] <= cfg_data;
                REG_COS_THR: cos_thr_reg <= cfg_data[15:0];
                REG_MAX_DIST: max_dist_reg <= cfg_data[31:0];
                REG_CURV_FLOOR: curv_floor_reg <= cfg_data[15:0];
                REG_RATIO_LIM: ratio_lim_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Stage 1: unpack and multiply.
    logic v1_reg, fs1_reg;
    logic [IDX_W-1:0] ri1_reg, ci1_reg;
    logic signed [31:0] pp1_reg [3][3];
    logic signed [31:0] pn1_reg [3][3];
    logic signed [15:0] cp1_reg [3];
    logic signed [15:0] cn1_reg [3];
    logic [15:0] rc1_reg, cc1_reg;
    logic in_ok;
    assign in_ok = !s_tdata[19] && !s_tdata[39];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            fs1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid && in_ok;
            fs1_reg <= s_tvalid && s_tuser;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ri1_reg <= s_tdata[18:0];
            ci1_reg <= s_tdata[38:20];
            rc1_reg <= s_tdata[247:232];
            cc1_reg <= s_tdata[263:248];
            for (int i = 0; i < 3; i++)
            begin
                cp1_reg[i] <= s_tdata[136 + 32 - 16*i +: 16];
                cn1_reg[i] <= s_tdata[184 + 32 - 16*i +: 16];
                for (int j = 0; j < 3; j++)
                begin
                    pp1_reg[i][j] <= $signed(row_reg[i][48 - 16*j +: 16])
                                   * $signed(s_tdata[40 + 32 - 16*j +: 16]);
                    pn1_reg[i][j] <= $signed(row_reg[i][48 - 16*j +: 16])
                                   * $signed(s_tdata[88 + 32 - 16*j +: 16]);
                end
            end
        end
    end

    // Stage 2: row sums, rounding, translation and difference.
    logic v2_reg, fs2_reg;
    logic [IDX_W-1:0] ri2_reg, ci2_reg;
    logic signed [33:0] an2_reg [3];
    logic signed [20:0] d2_reg [3];
    logic signed [15:0] cn2_reg [3];
    logic [16:0] a2_reg, b2_reg;
    logic signed [33:0] sp [3];
    logic signed [20:0] tp [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sp[i] = 34'(pp1_reg[i][0]) + 34'(pp1_reg[i][1]) + 34'(pp1_reg[i][2])
                  + 34'sd8192;
            tp[i] = 21'(sp[i] >>> 14) + 21'($signed(row_reg[i][15:0]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            fs2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
            fs2_reg <= fs1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ri2_reg <= ri1_reg;
            ci2_reg <= ci1_reg;
            a2_reg <= ((rc1_reg < curv_floor_reg) ? {1'b0, curv_floor_reg} : {1'b0, rc1_reg})
                      + 17'd1;
            b2_reg <= ((cc1_reg < curv_floor_reg) ? {1'b0, curv_floor_reg} : {1'b0, cc1_reg})
                      + 17'd1;
            for (int i = 0; i < 3; i++)
            begin
                an2_reg[i] <= 34'(pn1_reg[i][0]) + 34'(pn1_reg[i][1]) + 34'(pn1_reg[i][2]);
                d2_reg[i] <= 21'(cp1_reg[i]) - tp[i];
                cn2_reg[i] <= cn1_reg[i];
            end
        end
    end

    // Stage 3: squares, dot terms and curvature cross products.
    logic v3_reg, fs3_reg;
    logic [IDX_W-1:0] ri3_reg, ci3_reg;
    logic [40:0] sq3_reg [3];
    logic signed [49:0] dt3_reg [3];
    logic [32:0] x1_reg, x2_reg, x3_reg, x4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            fs3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
            fs3_reg <= fs2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ri3_reg <= ri2_reg;
            ci3_reg <= ci2_reg;
            x1_reg <= {8'd0, a2_reg, 8'd0};
            x2_reg <= 33'(ratio_lim_reg) * 33'(b2_reg);
            x3_reg <= 33'(a2_reg) * 33'(ratio_lim_reg);
            x4_reg <= {8'd0, b2_reg, 8'd0};
            for (int i = 0; i < 3; i++)
            begin
                sq3_reg[i] <= 41'(42'(d2_reg[i]) * 42'(d2_reg[i]));
                dt3_reg[i] <= 50'(an2_reg[i]) * 50'(cn2_reg[i]);
            end
        end
    end

    // Stage 4: compare and count.
    logic [CNT_W-1:0] count_reg;
    logic [42:0] dist_sum;
    logic signed [51:0] dot;
    logic pass;
    logic [CNT_W-1:0] base;

    always_comb
    begin
        dist_sum = 43'(sq3_reg[0]) + 43'(sq3_reg[1]) + 43'(sq3_reg[2]);
        dot = 52'(dt3_reg[0]) + 52'(dt3_reg[1]) + 52'(dt3_reg[2]);
        base = fs3_reg ? '0 : count_reg;
        pass = v3_reg
            && !(dot < $signed({{8{cos_thr_reg[15]}}, cos_thr_reg, 28'd0}))
            && !(dist_sum > 43'(max_dist_reg))
            && !(x1_reg > x2_reg) && !(x3_reg < x4_reg)
            && (base < CNT_W'(LIST_CAP));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            m_tvalid <= 1'b0;
        end
        else if (adv)
        begin
            count_reg <= pass ? base + 1'b1 : base;
            m_tvalid <= pass;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tdata <= {7'd0, IDX_W'(base), ci3_reg, ri3_reg};
        end
    end
endmodule
`default_nettype wire
